[design/fsca_pkg.sv]
// Shared types and codes for the flash slot catalog allocator.
// No dependencies.
`timescale 1ns / 1ps
package fsca_pkg;

    localparam logic [1:0] K_BEGIN = 2'd0;
    localparam logic [1:0] K_DATA  = 2'd1;
    localparam logic [1:0] K_SHOW  = 2'd2;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_FLASH = 3'd1;
    localparam logic [2:0] ST_RANGE = 3'd2;
    localparam logic [2:0] ST_LEN   = 3'd3;
    localparam logic [2:0] ST_FULL  = 3'd4;
    localparam logic [2:0] ST_STATE = 3'd5;

    localparam logic [1:0] CFG_PART_READY = 2'd0;
    localparam logic [1:0] CFG_BUILTIN_W  = 2'd1;
    localparam logic [1:0] CFG_BUILTIN_H  = 2'd2;

    localparam int MAX_W     = 2048;
    localparam int MAX_H     = 1024;
    localparam int PAGE_MASK = 4095;

    typedef struct packed {
        logic [15:0] key;
        logic [11:0] w;
        logic [10:0] h;
        logic [18:0] base;
        logic [19:0] span;
        logic [19:0] length;
    } slot_rec_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] slot_id;
        logic [15:0] pix_width;
        logic [15:0] pix_height;
        logic [23:0] total_bytes;
        logic [23:0] chunk_offset;
        logic [23:0] chunk_len;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [18:0] found_offset;
        logic [11:0] found_width;
        logic [10:0] found_height;
        logic        upload_done;
    } rsp_t;

endpackage

[design/fsca_if.sv]
// Request and response channel interfaces (valid/ready).
// Depends on fsca_pkg.
`timescale 1ns / 1ps
interface fsca_req_if;
    import fsca_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] slot_id;
    logic [15:0] pix_width;
    logic [15:0] pix_height;
    logic [23:0] total_bytes;
    logic [23:0] chunk_offset;
    logic [23:0] chunk_len;
    modport source (output valid, kind, slot_id, pix_width, pix_height, total_bytes,
                    chunk_offset, chunk_len, input ready);
    modport sink (input valid, kind, slot_id, pix_width, pix_height, total_bytes,
                  chunk_offset, chunk_len, output ready);
endinterface

interface fsca_rsp_if;
    import fsca_pkg::*;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [18:0] found_offset;
    logic [11:0] found_width;
    logic [10:0] found_height;
    logic        upload_done;
    modport source (output valid, status, found_offset, found_width, found_height,
                    upload_done, input ready);
    modport sink (input valid, status, found_offset, found_width, found_height,
                  upload_done, output ready);
endinterface

[design/flash_slot_catalog_allocator_core.sv]
// Top level of the flash slot catalog allocator: control, scans, upload state.
// Depends on fsca_pkg, fsca_if (fsca_req_if, fsca_rsp_if) and fsca_ram.
`timescale 1ns / 1ps
//
//  channel | dir | handshake      | payload
//  --------+-----+----------------+-----------------------------------------------
//  req     | in  | valid/ready    | kind, slot_id, pix_width/height, total_bytes,
//          |     |                | chunk_offset, chunk_len
//  rsp     | out | valid/ready    | status, found_offset/width/height, upload_done
//  cfg     | in  | cfg_we         | cfg_idx, cfg_wdata
//
//  One word at a time. Data chunks and bad begins go through the result register
//  and the finish state to the output register. Show and begin run a lookup scan
//  of the slot RAM; begin then runs further RAM passes, one per live offset in
//  ascending order, for the first-fit sweep. All scans share the single read port.
//  Reset clears valid bits and upload state at once; no clearing pass.
//  A stalled output holds the finished word; a new request is taken meanwhile.
module flash_slot_catalog_allocator_core #(
    parameter int NUM_SLOTS = 16,
    parameter int PART_SIZE = 524288,
    parameter int DIR_SIZE  = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [11:0] cfg_wdata,
    fsca_req_if.sink    req,
    fsca_rsp_if.source  rsp
);
    import fsca_pkg::*;

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int AW = 26;   // room for partition sizes and base+span sums
    localparam logic [AW-1:0] PART   = AW'(PART_SIZE);
    localparam logic [AW-1:0] DIR    = AW'(DIR_SIZE);
    localparam logic [IW:0]   NSLOTS = (IW+1)'(NUM_SLOTS);
    localparam logic [IW-1:0] LAST   = IW'(NUM_SLOTS - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOOK = 4'b0010,
        S_GAP  = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic        part_ready_reg;
    logic [11:0] bw_reg;
    logic [10:0] bh_reg;

    // captured request
    logic [1:0]  kind_reg, kind_next;
    logic [15:0] key_reg, key_next;
    logic [11:0] pw_reg, pw_next;
    logic [10:0] ph_reg, ph_next;
    logic [19:0] tot_reg, tot_next;
    logic [19:0] want_reg, want_next;

    rsp_t res_reg, res_next;
    rsp_t out_reg, out_next;
    logic out_valid_reg, out_valid_next;

    // RAM scan sequencing
    logic [IW:0]   issue_reg, issue_next;
    logic          pend_reg, pend_next;
    logic [IW-1:0] pidx_reg, pidx_next;

    // lookup results
    logic          found_reg, found_next;
    logic [IW-1:0] midx_reg, midx_next;
    logic [11:0]   mw_reg, mw_next;
    logic [10:0]   mh_reg, mh_next;
    logic [18:0]   mb_reg, mb_next;

    // gap sweep
    logic [IW-1:0] skip_reg, skip_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [18:0]   prev_reg, prev_next;
    logic          hprev_reg, hprev_next;
    logic          bany_reg, bany_next;
    logic [18:0]   bb_reg, bb_next;
    logic [AW-1:0] bend_reg, bend_next;

    // upload and slot valid bits
    logic [NUM_SLOTS-1:0] valid_reg, valid_next;
    logic          uopen_reg, uopen_next;
    logic [IW-1:0] uslot_reg, uslot_next;
    logic [15:0]   ukey_reg, ukey_next;
    logic [11:0]   uw_reg, uw_next;
    logic [10:0]   uh_reg, uh_next;
    logic [18:0]   ubase_reg, ubase_next;
    logic [19:0]   uspan_reg, uspan_next;
    logic [19:0]   utot_reg, utot_next;
    logic [19:0]   ugot_reg, ugot_next;

    // RAM
    logic          ram_we, ram_re;
    logic [IW-1:0] ram_raddr;
    slot_rec_t     ram_wdata, ram_rdata;

    fsca_ram #(
        .WIDTH ($bits(slot_rec_t)),
        .DEPTH (NUM_SLOTS),
        .AW    (IW)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (uslot_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_reg.status;
    assign rsp.found_offset = out_reg.found_offset;
    assign rsp.found_width  = out_reg.found_width;
    assign rsp.found_height = out_reg.found_height;
    assign rsp.upload_done  = out_reg.upload_done;

    wire accept = req.valid && req.ready;

    // begin checks, done at accept
    logic        bad_range, bad_len, bad_span;
    logic [19:0] need;
    logic [20:0] span_raw;
    always_comb
    begin
        bad_range = (req.pix_width == 16'd0) || (req.pix_height == 16'd0)
                 || (req.pix_width[1:0] != 2'd0)
                 || (req.pix_width > 16'(MAX_W)) || (req.pix_height > 16'(MAX_H));
        need      = 20'(req.pix_width[11:2] * req.pix_height[10:0]);
        bad_len   = (req.total_bytes == 24'd0) || (req.total_bytes != {4'd0, need});
        span_raw  = (21'(req.total_bytes[19:0]) + 21'(PAGE_MASK)) & ~21'(PAGE_MASK);
        bad_span  = AW'(span_raw) > (PART - DIR);
    end

    // first free slot
    logic          free_any;
    logic [IW-1:0] free_idx;
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    // per-entry views of the word coming out of the RAM
    logic          scan_end;
    logic          hit;
    logic          cand;
    logic [AW-1:0] r_base, r_span, r_end;
    always_comb
    begin
        r_base   = AW'(ram_rdata.base);
        r_span   = AW'(ram_rdata.span);
        r_end    = r_base + r_span;
        scan_end = pend_reg && (pidx_reg == LAST);
        hit      = pend_reg && valid_reg[pidx_reg] && (ram_rdata.key == key_reg);
        cand     = pend_reg && valid_reg[pidx_reg] && (pidx_reg != skip_reg)
                && (r_span != '0) && (r_base >= DIR) && (r_span <= PART)
                && (r_base <= PART - r_span)
                && (!hprev_reg || (ram_rdata.base > prev_reg));
    end

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        key_next       = key_reg;
        pw_next        = pw_reg;
        ph_next        = ph_reg;
        tot_next       = tot_reg;
        want_next      = want_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        issue_next     = issue_reg;
        pend_next      = 1'b0;
        pidx_next      = pidx_reg;
        found_next     = found_reg;
        midx_next      = midx_reg;
        mw_next        = mw_reg;
        mh_next        = mh_reg;
        mb_next        = mb_reg;
        skip_next      = skip_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        hprev_next     = hprev_reg;
        bany_next      = bany_reg;
        bb_next        = bb_reg;
        bend_next      = bend_reg;
        valid_next     = valid_reg;
        uopen_next     = uopen_reg;
        uslot_next     = uslot_reg;
        ukey_next      = ukey_reg;
        uw_next        = uw_reg;
        uh_next        = uh_reg;
        ubase_next     = ubase_reg;
        uspan_next     = uspan_reg;
        utot_next      = utot_reg;
        ugot_next      = ugot_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = issue_reg[IW-1:0];
        ram_wdata      = '{key: ukey_reg, w: uw_reg, h: uh_reg, base: ubase_reg,
                           span: uspan_reg, length: utot_reg};

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        // scan sequencer shared by lookup and gap passes
        if ((state_reg == S_LOOK) || (state_reg == S_GAP))
        begin
            if (issue_reg < NSLOTS)
            begin
                ram_re     = 1'b1;
                pend_next  = 1'b1;
                pidx_next  = issue_reg[IW-1:0];
                issue_next = issue_reg + 1'b1;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next  = req.kind;
                    key_next   = req.slot_id;
                    pw_next    = req.pix_width[11:0];
                    ph_next    = req.pix_height[10:0];
                    tot_next   = req.total_bytes[19:0];
                    want_next  = span_raw[19:0];
                    res_next   = '0;
                    issue_next = '0;
                    found_next = 1'b0;
                    state_next = S_FIN;
                    case (req.kind)
                        K_BEGIN:
                        begin
                            if (!part_ready_reg)
                                res_next.status = ST_FLASH;
                            else if (bad_range)
                                res_next.status = ST_RANGE;
                            else if (bad_len)
                                res_next.status = ST_LEN;
                            else if (bad_span)
                                res_next.status = ST_RANGE;
                            else
                                state_next = S_LOOK;
                        end
                        K_DATA:
                        begin
                            if (!uopen_reg || (req.chunk_offset != {4'd0, ugot_reg})
                                || (req.chunk_len > 24'(utot_reg - ugot_reg)))
                            begin
                                res_next.status = ST_STATE;
                            end
                            else
                            begin
                                ugot_next = ugot_reg + req.chunk_len[19:0];
                                if (ugot_next == utot_reg)
                                begin
                                    ram_we                = 1'b1;
                                    valid_next[uslot_reg] = 1'b1;
                                    uopen_next            = 1'b0;
                                    res_next.upload_done  = 1'b1;
                                end
                            end
                        end
                        K_SHOW:
                        begin
                            state_next = S_LOOK;
                        end
                        default:
                        begin
                            res_next.status = ST_STATE;
                        end
                    endcase
                end
            end

            S_LOOK:
            begin
                if (hit && !found_reg)
                begin
                    found_next = 1'b1;
                    midx_next  = pidx_reg;
                    mw_next    = ram_rdata.w;
                    mh_next    = ram_rdata.h;
                    mb_next    = ram_rdata.base;
                end
                if (scan_end)
                begin
                    state_next = S_FIN;
                    if (kind_reg == K_SHOW)
                    begin
                        if (found_next)
                        begin
                            res_next.found_width  = mw_next;
                            res_next.found_height = mh_next;
                            res_next.found_offset = mb_next;
                        end
                        else if (key_reg == 16'd0)
                        begin
                            res_next.found_width  = bw_reg;
                            res_next.found_height = bh_reg;
                        end
                        else
                        begin
                            res_next.status = ST_RANGE;
                        end
                        if ((res_next.found_width == 12'd0) || (res_next.found_height == 11'd0)
                            || (res_next.found_width[1:0] != 2'd0))
                        begin
                            res_next.status       = ST_RANGE;
                            res_next.found_offset = '0;
                        end
                    end
                    else if (!found_next && !free_any)
                    begin
                        res_next.status = ST_FULL;
                    end
                    else
                    begin
                        // a free slot is never live, so skipping it changes nothing
                        skip_next  = found_next ? midx_next : free_idx;
                        cur_next   = DIR;
                        hprev_next = 1'b0;
                        bany_next  = 1'b0;
                        issue_next = '0;
                        state_next = S_GAP;
                    end
                end
            end

            S_GAP:
            begin
                // smallest live offset above the previous one, widest end among ties
                if (cand)
                begin
                    if (!bany_reg || (ram_rdata.base < bb_reg))
                    begin
                        bany_next = 1'b1;
                        bb_next   = ram_rdata.base;
                        bend_next = r_end;
                    end
                    else if ((ram_rdata.base == bb_reg) && (r_end > bend_reg))
                    begin
                        bend_next = r_end;
                    end
                end
                if (scan_end)
                begin
                    if (!bany_next)
                    begin
                        state_next = S_FIN;
                        if ((cur_reg < PART) && (PART - cur_reg >= AW'(want_reg)))
                            res_next.found_offset = cur_reg[18:0];
                        else
                            res_next.status = ST_FULL;
                    end
                    else if ((AW'(bb_next) > cur_reg)
                             && (AW'(bb_next) - cur_reg >= AW'(want_reg)))
                    begin
                        state_next            = S_FIN;
                        res_next.found_offset = cur_reg[18:0];
                    end
                    else
                    begin
                        if (bend_next > cur_reg)
                            cur_next = bend_next;
                        prev_next  = bb_next;
                        hprev_next = 1'b1;
                        bany_next  = 1'b0;
                        issue_next = '0;
                    end
                    if ((state_next == S_FIN) && (res_next.status == ST_OK))
                    begin
                        valid_next[skip_reg] = 1'b0;
                        uopen_next = 1'b1;
                        uslot_next = skip_reg;
                        ukey_next  = key_reg;
                        uw_next    = pw_reg;
                        uh_next    = ph_reg;
                        ubase_next = cur_reg[18:0];
                        uspan_next = want_reg;
                        utot_next  = tot_reg;
                        ugot_next  = '0;
                    end
                end
            end

            S_FIN:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            part_ready_reg <= 1'b0;
            bw_reg         <= '0;
            bh_reg         <= '0;
            out_valid_reg  <= 1'b0;
            pend_reg       <= 1'b0;
            issue_reg      <= '0;
            valid_reg      <= '0;
            uopen_reg      <= 1'b0;
            uslot_reg      <= '0;
            ukey_reg       <= '0;
            uw_reg         <= '0;
            uh_reg         <= '0;
            ubase_reg      <= '0;
            uspan_reg      <= '0;
            utot_reg       <= '0;
            ugot_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            issue_reg     <= issue_next;
            valid_reg     <= valid_next;
            uopen_reg     <= uopen_next;
            uslot_reg     <= uslot_next;
            ukey_reg      <= ukey_next;
            uw_reg        <= uw_next;
            uh_reg        <= uh_next;
            ubase_reg     <= ubase_next;
            uspan_reg     <= uspan_next;
            utot_reg      <= utot_next;
            ugot_reg      <= ugot_next;
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    CFG_PART_READY: part_ready_reg <= cfg_wdata[0];
                    CFG_BUILTIN_W:  bw_reg         <= cfg_wdata;
                    CFG_BUILTIN_H:  bh_reg         <= cfg_wdata[10:0];
                    default:        ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        key_reg   <= key_next;
        pw_reg    <= pw_next;
        ph_reg    <= ph_next;
        tot_reg   <= tot_next;
        want_reg  <= want_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
        pidx_reg  <= pidx_next;
        found_reg <= found_next;
        midx_reg  <= midx_next;
        mw_reg    <= mw_next;
        mh_reg    <= mh_next;
        mb_reg    <= mb_next;
        skip_reg  <= skip_next;
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        hprev_reg <= hprev_next;
        bany_reg  <= bany_next;
        bb_reg    <= bb_next;
        bend_reg  <= bend_next;
    end

    // slot commits never land while a scan reads the RAM
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_IDLE))
        else $error("slot RAM written during a scan");

    // an open upload always has bytes still to come
    a_upload_short: assert property (@(posedge clk) disable iff (!rst_n)
        uopen_reg |-> (ugot_reg < utot_reg))
        else $error("open upload already complete");

    // a new response only follows the finish state
    a_rsp_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("response raised outside finish");

    // a committing chunk marks its slot live
    a_commit_live: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> valid_reg[$past(uslot_reg)])
        else $error("committed slot not marked valid");

endmodule

[design/fsca_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module fsca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

[tb/fsca_tb_if.sv]
// Testbench-side notes for the channel interfaces of the slot catalog allocator.
// The interfaces themselves come from the design (fsca_req_if, fsca_rsp_if); this file
// holds the small shared pieces the bench uses with them. Depends on fsca_pkg.
`timescale 1ns / 1ps
package fsca_tb_pkg;
    import fsca_pkg::*;

    // One request word as the bench builds it.
    typedef struct {
        logic [1:0]  kind;
        logic [15:0] slot_id;
        logic [15:0] pix_width;
        logic [15:0] pix_height;
        logic [23:0] total_bytes;
        logic [23:0] chunk_offset;
        logic [23:0] chunk_len;
    } cmd_t;

    // Expected response word.
    typedef struct {
        logic [2:0]  status;
        logic [18:0] found_offset;
        logic [11:0] found_width;
        logic [10:0] found_height;
        logic        upload_done;
    } reply_t;
endpackage

[tb/testbench.sv]
// Self-checking bench for flash_slot_catalog_allocator_core: a slot-table model predicts
// every response word; random valid/ready gaps on both channels.
// Depends on fsca_pkg, fsca_tb_pkg, fsca_if and the design.
`timescale 1ns / 1ps

import fsca_pkg::*;
import fsca_tb_pkg::*;

// Catalog model plus queue of expected replies.
class catalog_scoreboard;
    localparam int NSLOT = 16;
    localparam int PSIZE = 524288;
    localparam int DSIZE = 4096;

    bit          part_ready;
    logic [11:0] bi_w = '0;
    logic [10:0] bi_h = '0;

    bit          s_valid [NSLOT];
    logic [15:0] s_key   [NSLOT];
    logic [11:0] s_w     [NSLOT];
    logic [10:0] s_h     [NSLOT];
    int unsigned s_base  [NSLOT];
    int unsigned s_span  [NSLOT];

    bit          up_open;
    int          up_slot;
    logic [15:0] up_key;
    logic [11:0] up_w;
    logic [10:0] up_h;
    int unsigned up_base, up_span, up_total, up_got;

    reply_t pending_replies[$];
    int     errors;
    int     n_ok, n_done, n_err;

    function void set_reg(logic [1:0] idx, logic [11:0] val);
        if (idx == CFG_PART_READY) part_ready = val[0];
        else if (idx == CFG_BUILTIN_W) bi_w = val;
        else if (idx == CFG_BUILTIN_H) bi_h = val[10:0];
    endfunction

    function int find_key(logic [15:0] k);
        for (int i = 0; i < NSLOT; i++)
            if (s_valid[i] && s_key[i] == k) return i;
        return -1;
    endfunction

    // First fit after the directory, skipping one slot and malformed records.
    function bit first_fit(int unsigned want, int skip, output int unsigned where);
        int unsigned so[$];
        int unsigned sc[$];
        int unsigned cur, kb, ks, e;
        int j;
        cur = DSIZE;
        where = 0;
        for (int i = 0; i < NSLOT; i++) begin
            if (i == skip || !s_valid[i]) continue;
            if (s_span[i] == 0 || s_base[i] < DSIZE || s_span[i] > PSIZE ||
                s_base[i] > PSIZE - s_span[i]) continue;
            so.push_back(s_base[i]);
            sc.push_back(s_span[i]);
        end
        for (int i = 1; i < so.size(); i++) begin
            kb = so[i];
            ks = sc[i];
            j = i;
            while (j > 0 && so[j-1] > kb) begin
                so[j] = so[j-1];
                sc[j] = sc[j-1];
                j--;
            end
            so[j] = kb;
            sc[j] = ks;
        end
        for (int i = 0; i < so.size(); i++) begin
            if (so[i] > cur && so[i] - cur >= want) begin
                where = cur;
                return 1;
            end
            e = so[i] + sc[i];
            if (e > cur) cur = e;
        end
        if (cur < PSIZE && PSIZE - cur >= want) begin
            where = cur;
            return 1;
        end
        return 0;
    endfunction

    function logic [2:0] run_begin(cmd_t c, output int unsigned offs);
        int unsigned w, h, tot, span, where;
        int idx;
        bit live;
        offs = 0;
        w = c.pix_width;
        h = c.pix_height;
        tot = c.total_bytes;
        if (!part_ready) return ST_FLASH;
        if (w == 0 || h == 0 || w % 4 != 0 || w > MAX_W || h > MAX_H) return ST_RANGE;
        if (tot == 0 || tot != (w / 4) * h) return ST_LEN;
        span = (tot + PAGE_MASK) & ~PAGE_MASK;
        if (span > PSIZE - DSIZE) return ST_RANGE;
        idx = find_key(c.slot_id);
        if (idx < 0)
            for (int i = 0; i < NSLOT; i++)
                if (!s_valid[i]) begin
                    idx = i;
                    break;
                end
        if (idx < 0) return ST_FULL;
        live = s_valid[idx];
        if (!first_fit(span, live ? idx : -1, where)) return ST_FULL;
        if (live) s_valid[idx] = 0;
        up_open = 1;
        up_slot = idx;
        up_key = c.slot_id;
        up_w = w;
        up_h = h;
        up_base = where;
        up_span = span;
        up_total = tot;
        up_got = 0;
        offs = where;
        return ST_OK;
    endfunction

    function logic [2:0] run_data(cmd_t c, output bit done);
        done = 0;
        if (!up_open) return ST_STATE;
        if (c.chunk_offset != up_got || c.chunk_len > up_total - up_got) return ST_STATE;
        up_got += c.chunk_len;
        if (up_got != up_total) return ST_OK;
        s_key[up_slot] = up_key;
        s_w[up_slot] = up_w;
        s_h[up_slot] = up_h;
        s_valid[up_slot] = 1;
        s_base[up_slot] = up_base;
        s_span[up_slot] = up_span;
        up_open = 0;
        done = 1;
        return ST_OK;
    endfunction

    // Note an accepted request: update the model and queue its reply.
    function void note_request(cmd_t c);
        reply_t r;
        int unsigned offs;
        bit done;
        int idx;
        r = '{default: '0};
        case (c.kind)
            K_BEGIN: begin
                r.status = run_begin(c, offs);
                r.found_offset = offs;
            end
            K_DATA: begin
                r.status = run_data(c, done);
                r.upload_done = done;
            end
            K_SHOW: begin
                idx = find_key(c.slot_id);
                if (idx >= 0) begin
                    r.found_width = s_w[idx];
                    r.found_height = s_h[idx];
                    r.found_offset = s_base[idx];
                end else if (c.slot_id == 0) begin
                    r.found_width = bi_w;
                    r.found_height = bi_h;
                end
                if (idx < 0 && c.slot_id != 0) r.status = ST_RANGE;
                else if (r.found_width == 0 || r.found_height == 0 || r.found_width[1:0] != 0)
                    r.status = ST_RANGE;
                else r.status = ST_OK;
                if (r.status != ST_OK) r.found_offset = 0;
            end
            default: r.status = ST_STATE;
        endcase
        if (r.status == ST_OK) n_ok++;
        else n_err++;
        if (r.upload_done) n_done++;
        pending_replies.push_back(r);
    endfunction

    // Compare one accepted response word with the oldest expectation.
    function void check_reply(reply_t a);
        reply_t e;
        if (pending_replies.size() == 0) begin
            $error("unexpected response word, status %0d", a.status);
            errors++;
            return;
        end
        e = pending_replies.pop_front();
        if (a.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, a.status);
            errors++;
        end
        if (a.found_offset !== e.found_offset) begin
            $error("found_offset: expected %0h, got %0h", e.found_offset, a.found_offset);
            errors++;
        end
        if (a.found_width !== e.found_width) begin
            $error("found_width: expected %0d, got %0d", e.found_width, a.found_width);
            errors++;
        end
        if (a.found_height !== e.found_height) begin
            $error("found_height: expected %0d, got %0d", e.found_height, a.found_height);
            errors++;
        end
        if (a.upload_done !== e.upload_done) begin
            $error("upload_done: expected %0d, got %0d", e.upload_done, a.upload_done);
            errors++;
        end
    endfunction
endclass

module testbench;
    import fsca_pkg::*;
    import fsca_tb_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [11:0] cfg_wdata;

    fsca_req_if req ();
    fsca_rsp_if rsp ();

    flash_slot_catalog_allocator_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .req       (req.sink),
        .rsp       (rsp.source)
    );

    catalog_scoreboard sb;
    bit no_stall;      // stretches with no request gaps and the response side always ready
    int n_items;

    initial begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // Generous cap: allows for the slowest begin, plus gaps on both sides.
    initial begin
        #(4ns * 2000000);
        $display("Test completed with failures");
        $finish;
    end

    // Register write: one cycle of cfg_we at an idle point.
    task automatic write_reg(logic [1:0] idx, logic [11:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    // Present one word, hold it until accepted, then note it in the model.
    // Valid stays high after acceptance; the next word, a gap or drain() drops it.
    task automatic send_word(cmd_t c);
        int gap;
        gap = no_stall ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.kind <= c.kind;
        req.slot_id <= c.slot_id;
        req.pix_width <= c.pix_width;
        req.pix_height <= c.pix_height;
        req.total_bytes <= c.total_bytes;
        req.chunk_offset <= c.chunk_offset;
        req.chunk_len <= c.chunk_len;
        do @(posedge clk); while (!req.ready);
        sb.note_request(c);
        n_items++;
    endtask

    // Wait until every reply has come back, then let a data-path pipeline drain.
    task automatic drain();
        req.valid <= 1'b0;
        while (sb.pending_replies.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic cmd_t noise_word();
        cmd_t c;
        c.kind = $urandom_range(0, 3);
        c.slot_id = $urandom;
        c.pix_width = $urandom;
        c.pix_height = $urandom;
        c.total_bytes = $urandom;
        c.chunk_offset = $urandom;
        c.chunk_len = $urandom;
        return c;
    endfunction

    function automatic cmd_t begin_word(logic [15:0] id, int w, int h);
        cmd_t c;
        c = noise_word();
        c.kind = K_BEGIN;
        c.slot_id = id;
        c.pix_width = w;
        c.pix_height = h;
        c.total_bytes = (w / 4) * h;
        return c;
    endfunction

    function automatic cmd_t data_word(int at, int n);
        cmd_t c;
        c = noise_word();
        c.kind = K_DATA;
        c.chunk_offset = at;
        c.chunk_len = n;
        return c;
    endfunction

    function automatic cmd_t show_word(logic [15:0] id);
        cmd_t c;
        c = noise_word();
        c.kind = K_SHOW;
        c.slot_id = id;
        return c;
    endfunction

    // Full upload: begin, then in-order chunks; an occasional bad chunk mixed in.
    task automatic upload(logic [15:0] id, int w, int h);
        int tot, got, n;
        tot = (w / 4) * h;
        send_word(begin_word(id, w, h));
        got = 0;
        while (got < tot) begin
            if ($urandom_range(0, 9) == 0) send_word(data_word(got + 1, 1));
            n = $urandom_range(0, 3) == 0 ? tot - got : $urandom_range(0, tot - got);
            send_word(data_word(got, n));
            got += n;
        end
    endtask

    // Response sink: random ready, checks each accepted word.
    initial begin
        reply_t a;
        rsp.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rsp.valid && rsp.ready) begin
                a.status = rsp.status;
                a.found_offset = rsp.found_offset;
                a.found_width = rsp.found_width;
                a.found_height = rsp.found_height;
                a.upload_done = rsp.upload_done;
                sb.check_reply(a);
            end
            rsp.ready <= no_stall ? 1'b1 : ($urandom_range(0, 3) == 0);
        end
    end

    initial begin
        cmd_t c;
        int w, h, sel;
        logic [15:0] ids[8];
        sb = new();
        n_items = 0;
        no_stall = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_idx = CFG_PART_READY;
        cfg_wdata = 0;
        req.valid = 0;
        req.kind = K_BEGIN;
        req.slot_id = 0;
        req.pix_width = 0;
        req.pix_height = 0;
        req.total_bytes = 0;
        req.chunk_offset = 0;
        req.chunk_len = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: partition not ready, then bounds and special cases.
        send_word(begin_word(16'd5, 64, 8));
        send_word(show_word(16'd0));
        send_word(data_word(0, 0));
        drain();
        write_reg(CFG_PART_READY, 12'd1);
        write_reg(CFG_BUILTIN_W, 12'd2048);
        write_reg(CFG_BUILTIN_H, 12'd1024);
        send_word(show_word(16'd0));
        send_word(begin_word(16'd1, 0, 8));
        send_word(begin_word(16'd1, 6, 8));
        send_word(begin_word(16'd1, 2052, 8));
        send_word(begin_word(16'd1, 8, 1025));
        send_word(begin_word(16'd1, 8, 0));
        c = begin_word(16'd1, 8, 8);
        c.total_bytes = 24'hFFFFFF;
        send_word(c);
        c.kind = 2'd3;
        send_word(c);
        send_word(begin_word(16'hFFFF, 2048, 1024));  // largest bitmap
        send_word(data_word(1, 0));                    // no upload open
        send_word(data_word(0, 0));                    // no upload open
        send_word(data_word(0, 524288));
        send_word(data_word(524287, 1));              // no upload open
        send_word(data_word(0, 524288));
        send_word(show_word(16'hFFFF));
        send_word(show_word(16'h1234));
        upload(16'd0, 4, 1);                           // id 0 now held by a slot
        send_word(show_word(16'd0));
        drain();
        write_reg(CFG_BUILTIN_W, 12'd6);               // misaligned built-in width
        write_reg(CFG_BUILTIN_H, 12'd0);
        send_word(begin_word(16'd0, 4, 1));            // frees id 0 on its slot
        send_word(show_word(16'd0));
        drain();

        // Random phases; settings change between phases.
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_PART_READY, (ph % 4 == 3) ? 12'd0 : 12'd1);
            write_reg(CFG_BUILTIN_W, ph == 7 ? 12'd4092 : 12'($urandom_range(0, 512) * 4));
            write_reg(CFG_BUILTIN_H, ph == 7 ? 12'd2047 : 12'($urandom_range(0, 1024)));
            no_stall = (ph % 3 == 2);
            for (int i = 0; i < 8; i++) ids[i] = (i == 0) ? 16'd0 : 16'($urandom);
            for (int k = 0; k < 76; k++) begin
                sel = $urandom_range(0, 9);
                if (sel < 5) begin
                    // mostly small bitmaps, the odd large one fills the partition
                    if ($urandom_range(0, 15) == 0) begin
                        w = 4 * $urandom_range(256, 512);
                        h = $urandom_range(512, 1024);
                    end else begin
                        w = 4 * $urandom_range(1, 16);
                        h = $urandom_range(1, 64);
                    end
                    upload($urandom_range(0, 3) == 0 ? 16'($urandom) : ids[$urandom_range(0, 7)],
                           w, h);
                end else if (sel < 7) begin
                    send_word(show_word($urandom_range(0, 4) == 0 ? 16'($urandom)
                                                                  : ids[$urandom_range(0, 7)]));
                end else if (sel < 8) begin
                    c = begin_word(ids[$urandom_range(0, 7)], 4 * $urandom_range(1, 8), 4);
                    send_word(c);              // begin left open, later dropped
                end else begin
                    send_word(noise_word());
                end
            end
            drain();
        end

        repeat (20) @(posedge clk);
        $display("Covered %0d request words: %0d ok, %0d errors, %0d uploads committed.",
                 n_items, sb.n_ok, sb.n_err, sb.n_done);
        if (sb.errors == 0 && sb.pending_replies.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

[files.f]
design/fsca_pkg.sv
design/fsca_if.sv
design/fsca_ram.sv
design/flash_slot_catalog_allocator_core.sv
tb/fsca_tb_if.sv
tb/testbench.sv
